/* hdl/rwef_pkg.sv */
`timescale 1ns / 1ps
package rwef_pkg;

    localparam int HARM_W   = 6;
    localparam int RAD_W    = 8;
    localparam int COEFF_W  = 16;
    localparam int ENERGY_W = 32;
    localparam int TOTAL_W  = 38;
    localparam int HE_W     = 40;
    localparam int WE_W     = 46;
    localparam int FRAC_W   = 20;
    localparam int NUM_W    = 61;
    localparam int QUO_W    = 21;
    localparam int CNT_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [FRAC_W-1:0] PPM_SCALE = 20'd1000000;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HARM = 2'd1;
    localparam logic [1:0] ST_BAD_WIN  = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HARM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RAD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_RAD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD_MUL,
        S_LOAD_WR,
        S_Q_RANGE,
        S_Q_WALK,
        S_Q_DRAIN,
        S_Q_ZCHK,
        S_Q_MUL,
        S_Q_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             capture;
        logic             load_mul;
        logic             load_wr;
        logic             q_start;
        logic             q_range;
        logic             walk;
        logic             mul_init;
        logic             mul_step;
        logic             div_step;
        logic             set_status;
        logic [1:0]       status;
        logic             clear;
        logic             out_load;
        logic [CNT_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       h_bad;
        logic       win_bad;
        logic       k_last;
        logic       we_zero;
        logic       out_free;
    } t_sts;

endpackage

/* hdl/rwef_ctrl.sv */
`timescale 1ns / 1ps
module rwef_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rwef_pkg::t_sts i_sts,
    output rwef_pkg::t_cmd o_cmd
);

    rwef_pkg::t_state r_state, n_state;
    logic [rwef_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rwef_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rwef_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rwef_pkg::S_DECODE;
            end
            rwef_pkg::S_DECODE: begin
                unique case (i_sts.mode)
                    rwef_pkg::MODE_LOAD:
                        n_state = i_sts.h_bad ? rwef_pkg::S_IDLE : rwef_pkg::S_LOAD_MUL;
                    rwef_pkg::MODE_QUERY:
                        n_state = i_sts.h_bad ? rwef_pkg::S_DONE : rwef_pkg::S_Q_RANGE;
                    default: n_state = rwef_pkg::S_IDLE;
                endcase
            end
            rwef_pkg::S_LOAD_MUL: n_state = rwef_pkg::S_LOAD_WR;
            rwef_pkg::S_LOAD_WR:  n_state = rwef_pkg::S_IDLE;
            rwef_pkg::S_Q_RANGE:
                n_state = i_sts.win_bad ? rwef_pkg::S_DONE : rwef_pkg::S_Q_WALK;
            rwef_pkg::S_Q_WALK: begin
                if (i_sts.k_last) n_state = rwef_pkg::S_Q_DRAIN;
            end
            rwef_pkg::S_Q_DRAIN: n_state = rwef_pkg::S_Q_ZCHK;
            rwef_pkg::S_Q_ZCHK:
                n_state = i_sts.we_zero ? rwef_pkg::S_DONE : rwef_pkg::S_Q_MUL;
            rwef_pkg::S_Q_MUL: begin
                if (r_cnt == rwef_pkg::CNT_W'(rwef_pkg::FRAC_W - 1))
                    n_state = rwef_pkg::S_Q_DIV;
            end
            rwef_pkg::S_Q_DIV: begin
                if (r_cnt == rwef_pkg::CNT_W'(rwef_pkg::NUM_W - 1))
                    n_state = rwef_pkg::S_DONE;
            end
            rwef_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = rwef_pkg::S_IDLE;
            end
            default: n_state = rwef_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = (n_state != r_state) ? '0 : r_cnt + 1'b1;
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.idx  = r_cnt;
        o_in_ready = 1'b0;
        unique case (r_state)
            rwef_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            rwef_pkg::S_DECODE: begin
                if (i_sts.mode == rwef_pkg::MODE_QUERY) begin
                    o_cmd.q_start    = 1'b1;
                    o_cmd.set_status = i_sts.h_bad;
                    o_cmd.status     = rwef_pkg::ST_BAD_HARM;
                end
                o_cmd.clear = (i_sts.mode == rwef_pkg::MODE_CLEAR);
            end
            rwef_pkg::S_LOAD_MUL: o_cmd.load_mul = 1'b1;
            rwef_pkg::S_LOAD_WR:  o_cmd.load_wr  = 1'b1;
            rwef_pkg::S_Q_RANGE: begin
                o_cmd.q_range    = 1'b1;
                o_cmd.set_status = i_sts.win_bad;
                o_cmd.status     = rwef_pkg::ST_BAD_WIN;
            end
            rwef_pkg::S_Q_WALK: o_cmd.walk = 1'b1;
            rwef_pkg::S_Q_DRAIN: ;
            rwef_pkg::S_Q_ZCHK: begin
                o_cmd.mul_init   = 1'b1;
                o_cmd.set_status = 1'b1;
                o_cmd.status     = i_sts.we_zero ? rwef_pkg::ST_ZERO : rwef_pkg::ST_OK;
            end
            rwef_pkg::S_Q_MUL: o_cmd.mul_step = 1'b1;
            rwef_pkg::S_Q_DIV: o_cmd.div_step = 1'b1;
            rwef_pkg::S_DONE:  o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

/* hdl/rwef_dp.sv */
`timescale 1ns / 1ps
module rwef_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rwef_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rwef_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [1:0]                          i_mode,
    input  logic [rwef_pkg::HARM_W-1:0]         i_harmonic,
    input  logic [rwef_pkg::RAD_W-1:0]          i_radius,
    input  logic [rwef_pkg::RAD_W-1:0]          i_window,
    input  logic signed [rwef_pkg::COEFF_W-1:0] i_cos_coeff,
    input  logic signed [rwef_pkg::COEFF_W-1:0] i_sin_coeff,
    input  rwef_pkg::t_cmd                      i_cmd,
    output rwef_pkg::t_sts                      o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [rwef_pkg::FRAC_W-1:0]         o_fraction_ppm,
    output logic [rwef_pkg::HE_W-1:0]           o_harmonic_energy,
    output logic [rwef_pkg::WE_W-1:0]           o_window_energy,
    output logic [1:0]                          o_status
);

    localparam int NRAD  = 1 << rwef_pkg::RAD_W;
    localparam int NSTORE = 1 << (rwef_pkg::RAD_W + rwef_pkg::HARM_W);

    logic [6:0] r_hcount;
    logic       r_skip;
    logic [7:0] r_first, r_last, r_hop;
    logic [8:0] r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcount <= 7'd64;
            r_skip   <= 1'b0;
            r_first  <= 8'd0;
            r_last   <= 8'd255;
            r_hop    <= 8'd1;
            r_len    <= 9'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rwef_pkg::CFG_HARM_COUNT: r_hcount <= i_cfg_data[6:0];
                rwef_pkg::CFG_SKIP_FIRST: r_skip   <= i_cfg_data[0];
                rwef_pkg::CFG_FIRST_RAD:  r_first  <= i_cfg_data[7:0];
                rwef_pkg::CFG_LAST_RAD:   r_last   <= i_cfg_data[7:0];
                rwef_pkg::CFG_HOP:        r_hop    <= i_cfg_data[7:0];
                rwef_pkg::CFG_LENGTH:     r_len    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [1:0]                         r_mode;
    logic [rwef_pkg::HARM_W-1:0]        r_h;
    logic [rwef_pkg::RAD_W-1:0]         r_r, r_w;
    logic [rwef_pkg::COEFF_W-1:0]       r_cos, r_sin;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_h    <= i_harmonic;
            r_r    <= i_radius;
            r_w    <= i_window;
            r_cos  <= i_cos_coeff;
            r_sin  <= i_sin_coeff;
        end
    end

    function automatic logic [15:0] mag(input logic [15:0] raw);
        logic [16:0] neg;
        neg = 17'h10000 - {1'b0, raw};
        return raw[15] ? neg[15:0] : raw;
    endfunction

    logic [31:0] r_sq_c, r_sq_s;
    logic [32:0] e_sum;
    logic [rwef_pkg::ENERGY_W-1:0] e_new;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mul) begin
            r_sq_c <= mag(r_cos) * mag(r_cos);
            r_sq_s <= mag(r_sin) * mag(r_sin);
        end
    end

    assign e_sum = {1'b0, r_sq_c} + {1'b0, r_sq_s};
    assign e_new = e_sum[rwef_pkg::ENERGY_W-1:0];

    logic [rwef_pkg::ENERGY_W-1:0] m_energy [NSTORE];
    logic [rwef_pkg::TOTAL_W-1:0]  m_total  [NRAD];
    logic [NRAD-1:0]               r_tvld;
    logic [rwef_pkg::ENERGY_W-1:0] r_e_rd;
    logic [rwef_pkg::TOTAL_W-1:0]  r_t_rd;
    logic                          r_t_rd_vld;
    logic [rwef_pkg::RAD_W-1:0]    r_k, r_klast, t_addr;
    logic                          skip_tot;

    assign t_addr   = i_cmd.walk ? r_k : r_r;
    assign skip_tot = (r_h == '0) && r_skip;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) m_energy[{r_h, r_r}] <= e_new;
        r_e_rd <= m_energy[{r_h, r_k}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && !skip_tot)
            m_total[r_r] <= (r_t_rd_vld ? r_t_rd : '0) + rwef_pkg::TOTAL_W'(e_new);
        r_t_rd     <= m_total[t_addr];
        r_t_rd_vld <= r_tvld[t_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear)
            r_tvld <= '0;
        else if (i_cmd.load_wr && !skip_tot)
            r_tvld[r_r] <= 1'b1;
    end

    logic [16:0] r_start;
    logic [17:0] last_k;
    logic [7:0]  hop_eff;
    logic [8:0]  len_eff;

    assign hop_eff = (r_hop == '0) ? 8'd1 : r_hop;
    assign len_eff = (r_len == '0) ? 9'd1 : r_len;
    assign last_k  = {1'b0, r_start} + 18'(len_eff) - 18'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) r_start <= 17'(r_first) + 17'(r_w * hop_eff);
    end

    logic [rwef_pkg::HE_W-1:0]  r_he;
    logic [rwef_pkg::WE_W-1:0]  r_we;
    logic                       r_rd_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_v <= 1'b0;
        else          r_rd_v <= i_cmd.walk;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_range) begin
            r_k     <= r_start[7:0];
            r_klast <= last_k[7:0];
            r_he    <= '0;
            r_we    <= '0;
        end else begin
            if (i_cmd.walk) r_k <= r_k + 1'b1;
            if (r_rd_v) begin
                r_he <= r_he + rwef_pkg::HE_W'(r_e_rd);
                r_we <= r_we + (r_t_rd_vld ? rwef_pkg::WE_W'(r_t_rd) : '0);
            end
        end
    end

    logic [rwef_pkg::NUM_W-1:0] r_num, r_mul;
    logic [rwef_pkg::WE_W-1:0]  r_rem;
    logic [rwef_pkg::QUO_W-1:0] r_q;
    logic                       r_over;
    logic [rwef_pkg::WE_W:0]    sh, diff;
    logic                       qb;

    assign sh   = {r_rem, r_num[rwef_pkg::NUM_W-1]};
    assign diff = sh - {1'b0, r_we};
    assign qb   = (sh >= {1'b0, r_we});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_init) begin
            r_num  <= rwef_pkg::NUM_W'(r_we >> 1);
            r_mul  <= rwef_pkg::NUM_W'(r_he);
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
        end else if (i_cmd.mul_step) begin
            if (rwef_pkg::PPM_SCALE[i_cmd.idx[4:0]]) r_num <= r_num + r_mul;
            r_mul <= r_mul << 1;
        end else if (i_cmd.div_step) begin
            r_num  <= r_num << 1;
            r_rem  <= qb ? diff[rwef_pkg::WE_W-1:0] : sh[rwef_pkg::WE_W-1:0];
            r_q    <= {r_q[rwef_pkg::QUO_W-2:0], qb};
            r_over <= r_over | r_q[rwef_pkg::QUO_W-1];
        end
    end

    logic [1:0] r_st;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_status) r_st <= i_cmd.status;
    end

    logic [rwef_pkg::FRAC_W-1:0] frac_sat;
    logic                        keep_e;

    assign frac_sat = (r_over || r_q > rwef_pkg::QUO_W'(rwef_pkg::PPM_SCALE))
                    ? rwef_pkg::PPM_SCALE : r_q[rwef_pkg::FRAC_W-1:0];
    assign keep_e   = (r_st == rwef_pkg::ST_OK) || (r_st == rwef_pkg::ST_ZERO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            o_out_valid <= 1'b0;
        else if (i_cmd.out_load)
            o_out_valid <= 1'b1;
        else if (i_out_ready)
            o_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_fraction_ppm    <= (r_st == rwef_pkg::ST_OK) ? frac_sat : '0;
            o_harmonic_energy <= keep_e ? r_he : '0;
            o_window_energy   <= keep_e ? r_we : '0;
            o_status          <= r_st;
        end
    end

    assign o_sts.mode     = r_mode;
    assign o_sts.h_bad    = {1'b0, r_h} >= r_hcount;
    assign o_sts.win_bad  = last_k > 18'(r_last);
    assign o_sts.k_last   = (r_k == r_klast);
    assign o_sts.we_zero  = (r_we == '0);
    assign o_sts.out_free = !o_out_valid || i_out_ready;

endmodule

/* hdl/radial_window_energy_fraction_unit.sv */
`timescale 1ns / 1ps
// Radial window energy fraction unit.
// Input stream: tuser carries the mode (load, query, clear); tdata carries the
// harmonic, radius, window and the two signed coefficients. A load stores the
// pair energy cos^2+sin^2 and, unless skip-first and harmonic 0, adds it to the
// radius total; a clear zeroes all radius totals; only a query makes an output beat.
// Output stream: tdata carries fraction_ppm, harmonic_energy, window_energy;
// tuser carries the status (ok, bad harmonic, bad window, zero total).
// One item is in work at a time. A load passes a multiply state and a write
// state. A query reads one window radius per cycle on the single read port of
// each store, then runs 20 shift-add steps for the 1e6 scaling and a 61-step
// restoring divider. The output register holds a finished result while the
// receiver stalls; the next item is still accepted, and a later query waits
// only for that register. Reset (synchronous, active low) loads register
// defaults and marks all radius totals as zero at once; the energy store is
// not cleared and a query must only touch entries that were loaded. The user
// must make configuration writes only while idle; the block does not check it.
module radial_window_energy_fraction_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [8:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // harmonic[5:0], radius[13:6], window[21:14], cos_coeff[37:22], sin_coeff[53:38]
    input  logic [55:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // fraction_ppm[19:0], harmonic_energy[59:20], window_energy[105:60]
    output logic [111:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser
);

    rwef_pkg::t_cmd cmd;
    rwef_pkg::t_sts sts;
    logic [19:0]    frac;
    logic [39:0]    he;
    logic [45:0]    we;

    rwef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rwef_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (s_axis_tuser),
        .i_harmonic        (s_axis_tdata[5:0]),
        .i_radius          (s_axis_tdata[13:6]),
        .i_window          (s_axis_tdata[21:14]),
        .i_cos_coeff       (s_axis_tdata[37:22]),
        .i_sin_coeff       (s_axis_tdata[53:38]),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_fraction_ppm    (frac),
        .o_harmonic_energy (he),
        .o_window_energy   (we),
        .o_status          (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, we, he, frac};

endmodule
